### src/gprd_pkg.sv
// gamepad radial deadzone: shared types, constants and command/status structs
// no dependencies
`default_nettype none
package gprd_pkg;

  localparam int AXIS_W  = 16;
  localparam int OUT_W   = 17;
  localparam int DZ_W    = 15;
  localparam int TRIG_W  = 8;
  localparam int BTN_W   = 16;
  localparam int SUM_W   = 31;
  localparam int MAG_W   = 16;
  localparam int PROD_W  = 32;

  localparam logic [BTN_W-1:0] BTN_MASK = 16'hF3FF;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd8192;
  localparam logic [TRIG_W-1:0] THR_RESET = 8'd30;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  localparam int SQRT_STEPS = 16;
  localparam int DIV_STEPS  = 17;

  // register indexes
  localparam logic [0:0] REG_DEADZONE  = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  // axis lane selector
  typedef enum logic [1:0] {
    AX_LX = 2'd0,
    AX_LY = 2'd1,
    AX_RX = 2'd2,
    AX_RY = 2'd3
  } axis_sel_t;

  typedef struct packed {
    logic      load;       // capture input item
    logic      stick;      // 0 left, 1 right
    logic      sq_start;   // start square/compare/sqrt for stick
    logic      div_start;  // start divide of one axis
    axis_sel_t axis;
    logic      result;     // update output register
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic act;
  } dp_sts_t;

endpackage
`default_nettype wire

### src/gamepad_radial_deadzone.sv
// gamepad radial deadzone: top level with apb registers and stream ports
// depends on gprd_pkg, gprd_ctrl, gprd_dp
//
// flow: each stick uses the one shared unit in turn (square, compare,
//   16-step sqrt, then a 17-step divide per axis)
// a new item is taken only after the last one reaches the output register; a
//   disconnected pad skips the unit, and a result left waiting holds the next item
// reset: rst_n synchronous; previous button store cleared, registers to 8192 and 30
`default_nettype none
module gamepad_radial_deadzone #(
  parameter int PAD_COUNT = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: pad_index, connected, left_x, left_y, right_x, right_y,
  //   button_word, left_trigger_raw, right_trigger_raw, zero pad
  input  wire logic [103:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: pad_out, active, stick1_x, stick1_y, stick2_x, stick2_y,
  //   buttons_now, buttons_before, left_trigger, right_trigger, zero pad
  output logic [119:0]      out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import gprd_pkg::*;

  logic [DZ_W-1:0]   dz_r;
  logic [TRIG_W-1:0] thr_r;
  logic              wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_r  <= DZ_RESET;
      thr_r <= THR_RESET;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_DEADZONE) dz_r <= cfg_pwdata[DZ_W-1:0];
      else thr_r <= cfg_pwdata[TRIG_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == REG_DEADZONE) cfg_prdata = {17'd0, dz_r};
      else cfg_prdata = {24'd0, thr_r};
    end
  end

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    fire;
  assign fire = in_tvalid && in_tready;

  gprd_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(fire), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .sts, .cmd
  );

  gprd_dp #(.PAD_COUNT(PAD_COUNT)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .deadzone(dz_r), .threshold(thr_r),
    .pad_index(in_tdata[1:0]), .connected(in_tdata[2]),
    .axes(in_tdata[66:3]), .button_word(in_tdata[82:67]),
    .lt_raw(in_tdata[90:83]), .rt_raw(in_tdata[98:91]),
    .pad_out(out_tdata[1:0]), .active(out_tdata[2]),
    .sticks(out_tdata[70:3]), .buttons_now(out_tdata[86:71]),
    .buttons_before(out_tdata[102:87]), .left_trigger(out_tdata[110:103]),
    .right_trigger(out_tdata[118:111])
  );
  assign out_tdata[119] = 1'b0;

endmodule
`default_nettype wire

### src/gprd_ctrl.sv
// gamepad radial deadzone: sequencing state machine
// depends on gprd_pkg
`default_nettype none
module gprd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire gprd_pkg::dp_sts_t sts,
  output gprd_pkg::dp_cmd_t     cmd
);
  import gprd_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_SQW   = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_DIVW  = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  logic      stick_r, stick_nxt;
  logic      ax_r, ax_nxt;
  logic      ovalid_r, ovalid_nxt;

  // output register can be taken while the next item works
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    stick_nxt  = stick_r;
    ax_nxt     = ax_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    cmd.stick  = stick_r;
    cmd.axis   = axis_sel_t'({stick_r, ax_r});
    if (out_valid && out_ready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          stick_nxt = 1'b0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (!sts.act) begin
          state_nxt = S_DONE;
        end else begin
          cmd.sq_start = 1'b1;
          state_nxt    = S_SQW;
        end
      end
      S_SQW: begin
        if (!sts.busy) begin
          ax_nxt    = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.busy) begin
          if (!ax_r) begin
            ax_nxt    = 1'b1;
            state_nxt = S_DIV;
          end else if (!stick_r) begin
            stick_nxt = 1'b1;
            state_nxt = S_SQ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        // wait for output register to drain
        if (!ovalid_r || out_ready) state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.result = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      stick_r  <= 1'b0;
      ax_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      stick_r  <= stick_nxt;
      ax_r     <= ax_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_result_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |-> (!ovalid_r || out_ready))
    else $error("result overwrites pending output");
  a_load_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE)
    else $error("load outside idle");
  a_out_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.result |=> out_valid)
    else $error("result not shown");
`endif

endmodule
`default_nettype wire

### src/gprd_dp.sv
// gamepad radial deadzone: datapath with squarer, bit-serial sqrt and divider
// depends on gprd_pkg
`default_nettype none
module gprd_dp #(
  parameter int PAD_COUNT = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gprd_pkg::dp_cmd_t            cmd,
  output gprd_pkg::dp_sts_t                 sts,
  input  wire logic [gprd_pkg::DZ_W-1:0]    deadzone,
  input  wire logic [gprd_pkg::TRIG_W-1:0]  threshold,
  input  wire logic [1:0]                   pad_index,
  input  wire logic                         connected,
  input  wire logic [4*gprd_pkg::AXIS_W-1:0] axes,
  input  wire logic [gprd_pkg::BTN_W-1:0]   button_word,
  input  wire logic [gprd_pkg::TRIG_W-1:0]  lt_raw,
  input  wire logic [gprd_pkg::TRIG_W-1:0]  rt_raw,
  output logic [1:0]                        pad_out,
  output logic                              active,
  output logic [4*gprd_pkg::OUT_W-1:0]      sticks,
  output logic [gprd_pkg::BTN_W-1:0]        buttons_now,
  output logic [gprd_pkg::BTN_W-1:0]        buttons_before,
  output logic [gprd_pkg::TRIG_W-1:0]       left_trigger,
  output logic [gprd_pkg::TRIG_W-1:0]       right_trigger
);
  import gprd_pkg::*;

  localparam int PW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  // captured item
  logic [1:0]            pad_r;
  logic                  act_r;
  logic [4*AXIS_W-1:0]   axes_r;
  logic [BTN_W-1:0]      btn_r;
  logic [TRIG_W-1:0]     lt_r, rt_r;
  logic [BTN_W-1:0]      before_r;
  logic                  in_range;
  logic [PW-1:0]         pidx;
  logic [BTN_W-1:0]      prev_r [PAD_COUNT];

  assign in_range = ({30'd0, pad_index} < PAD_COUNT);
  assign pidx     = PW'(pad_index);

  // per-pad previous button store, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAD_COUNT; i++) prev_r[i] <= '0;
    end else if (cmd.load && in_range) begin
      prev_r[pidx] <= connected ? (button_word & BTN_MASK) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pad_r    <= pad_index;
      act_r    <= connected && in_range;
      axes_r   <= axes;
      btn_r    <= button_word & BTN_MASK;
      lt_r     <= lt_raw;
      rt_r     <= rt_raw;
      before_r <= in_range ? prev_r[pidx] : '0;
    end
  end

  // select stick axes and take magnitudes
  logic signed [AXIS_W-1:0] sx, sy, sa;
  logic [AXIS_W:0]          ax, ay, aa;
  assign sx = axes_r[(cmd.stick ? 2 : 0)*AXIS_W +: AXIS_W];
  assign sy = axes_r[(cmd.stick ? 3 : 1)*AXIS_W +: AXIS_W];
  assign ax = sx[AXIS_W-1] ? 17'(-{sx[AXIS_W-1], sx}) : {1'b0, sx};
  assign ay = sy[AXIS_W-1] ? 17'(-{sy[AXIS_W-1], sy}) : {1'b0, sy};
  assign sa = axes_r[cmd.axis*AXIS_W +: AXIS_W];
  assign aa = sa[AXIS_W-1] ? 17'(-{sa[AXIS_W-1], sa}) : {1'b0, sa};

  // unit sequencing
  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_SQX  = 5'b00010,
    U_SQY  = 5'b00100,
    U_SQRT = 5'b01000,
    U_DIV  = 5'b10000
  } unit_t;

  unit_t              u_r;
  logic [4:0]         cnt_r;
  logic [SUM_W:0]     sum_r;      // up to 2^31
  logic [SUM_W:0]     rem_r;
  logic [MAG_W:0]     root_r;
  logic               dead_r;
  logic [MAG_W:0]     num_r;      // m - d
  logic [PROD_W:0]    prod;       // axis times (m - d)
  logic [OUT_W-1:0]   prod_r;     // low product bits still to shift in
  logic [OUT_W-1:0]   drem_r;
  logic               ovf_r;      // quotient at or above 2^17
  logic [16:0]        den;
  logic [OUT_W-1:0]   q_r;
  logic [4*OUT_W-1:0] st_r;
  logic [2*DZ_W-1:0]  dsq;
  logic [SUM_W+2:0]   trial;
  logic [OUT_W:0]     dtrial;

  assign den   = ONE_Q15 - {2'b0, deadzone};
  assign dsq   = deadzone * deadzone;
  assign prod  = aa * num_r;
  // restoring sqrt: two bits of radicand a step
  assign trial = {rem_r, sum_r[SUM_W:SUM_W-1]} - {root_r, 2'b01};
  assign dtrial = {drem_r, prod_r[OUT_W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= U_IDLE;
    end else begin
      case (u_r)
        U_IDLE: begin
          if (cmd.sq_start) u_r <= U_SQX;
          else if (cmd.div_start) u_r <= U_DIV;
        end
        U_SQX: u_r <= U_SQY;
        U_SQY: u_r <= U_SQRT;
        U_SQRT: if (cnt_r == 5'(SQRT_STEPS - 1)) u_r <= U_IDLE;
        U_DIV: if (cnt_r == 5'(DIV_STEPS - 1)) u_r <= U_IDLE;
        default: u_r <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (u_r)
      U_IDLE: begin
        cnt_r <= '0;
        if (cmd.sq_start) begin
          sum_r <= {1'b0, 31'(ax * ax)};
        end else if (cmd.div_start) begin
          // high product bits preload the remainder, 17 quotient bits follow
          drem_r <= {1'b0, prod[PROD_W:OUT_W]};
          prod_r <= prod[OUT_W-1:0];
          ovf_r  <= {1'b0, prod[PROD_W:OUT_W]} >= den;
          q_r    <= '0;
        end
      end
      U_SQX: begin
        sum_r  <= sum_r + {1'b0, 31'(ay * ay)};
      end
      U_SQY: begin
        dead_r <= sum_r < {2'b0, dsq};
        rem_r  <= '0;
        root_r <= '0;
      end
      U_SQRT: begin
        cnt_r <= cnt_r + 5'd1;
        sum_r <= {sum_r[SUM_W-2:0], 2'b00};
        if (!trial[SUM_W+2]) begin
          rem_r  <= trial[SUM_W:0];
          root_r <= {root_r[MAG_W-1:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[SUM_W-2:0], sum_r[SUM_W:SUM_W-1]};
          root_r <= {root_r[MAG_W-1:0], 1'b0};
        end
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          num_r <= (!trial[SUM_W+2] ? {root_r[MAG_W-1:0], 1'b1} : {root_r[MAG_W-1:0], 1'b0})
                   - {2'b0, deadzone};
        end
      end
      U_DIV: begin
        cnt_r <= cnt_r + 5'd1;
        prod_r <= {prod_r[OUT_W-2:0], 1'b0};
        if (!dtrial[OUT_W]) begin
          drem_r <= dtrial[OUT_W-1:0];
          q_r    <= {q_r[OUT_W-2:0], 1'b1};
        end else begin
          drem_r <= {drem_r[OUT_W-2:0], prod_r[OUT_W-1]};
          q_r    <= {q_r[OUT_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // restore sign and saturate to the signed 17-bit range
  logic             sat;
  logic [OUT_W-1:0] qs;
  assign sat = ovf_r | q_r[OUT_W-1];
  assign qs  = sa[AXIS_W-1] ? (sat ? 17'h10000 : -q_r) : (sat ? 17'h0FFFF : q_r);

  always_ff @(posedge clk) begin
    if (cmd.load) st_r <= '0;
    else if (u_r == U_IDLE && cmd.div_start == 1'b0 && cnt_r == 5'(DIV_STEPS)) begin
      st_r[cmd.axis*OUT_W +: OUT_W] <= dead_r ? '0 : qs;
    end
  end

  assign sts.busy = (u_r != U_IDLE);
  assign sts.act  = act_r;

  // output register
  always_ff @(posedge clk) begin
    if (cmd.result) begin
      pad_out        <= pad_r;
      active         <= act_r;
      sticks         <= act_r ? st_r : '0;
      buttons_now    <= act_r ? btn_r : '0;
      buttons_before <= before_r;
      left_trigger   <= (act_r && lt_r > threshold) ? lt_r : '0;
      right_trigger  <= (act_r && rt_r > threshold) ? rt_r : '0;
    end
  end

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    u_r == U_DIV |-> den != '0)
    else $error("zero divisor");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sq_start || cmd.div_start) |-> u_r == U_IDLE)
    else $error("unit started while busy");
  a_sqrt_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(u_r == U_SQRT) |-> ##15 u_r == U_SQRT)
    else $error("sqrt ended early");
`endif

endmodule
`default_nettype wire
